/* rtl/core/ral_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ral_pkg
// Shared types and constants of the positional array list engine.
// ----------------------------------------------------------------------------
package ral_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned COUNT_W      = 9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FLUSH,
    S_PLACE,
    S_RDWAIT
  } state_e;

endpackage : ral_pkg
`default_nettype wire

/* rtl/core/ral_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ral_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ral_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : ral_ram
`default_nettype wire

/* rtl/core/ral_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ral_ctrl
// Sequencer of the list engine: decodes an item, keeps the length and moves
// entries through the RAM one per cycle for insert and delete.
// ----------------------------------------------------------------------------
module ral_ctrl #(
  parameter int unsigned CAPACITY = ral_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ral_pkg::FUNC_W-1:0]    func_i,
  input  wire logic [ral_pkg::POS_W-1:0]     position_i,
  input  wire logic [ral_pkg::DATA_W-1:0]    value_i,
  output logic                               done_o,
  output logic [ral_pkg::STAT_W-1:0]         status_o,
  output logic [ral_pkg::DATA_W-1:0]         read_value_o,
  output logic [ral_pkg::COUNT_W-1:0]        count_o,
  output logic                               mem_we_o,
  output logic [AW-1:0]                      mem_waddr_o,
  output logic [ral_pkg::DATA_W-1:0]         mem_wdata_o,
  output logic [AW-1:0]                      mem_raddr_o,
  input  wire logic [ral_pkg::DATA_W-1:0]    mem_rdata_i
);

  import ral_pkg::*;

  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [LW-1:0] LEN_CAP = LW'(CAPACITY);

  state_e            state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  logic              done_q, done_d;
  logic              pend_q, pend_d;
  logic              ins_q, ins_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  status_e           stat_q, stat_d;
  logic [DATA_W-1:0] rdval_q, rdval_d;

  func_e       func;
  logic        accept;
  logic [CW-1:0] pos_ext, len_ext;
  logic [AW-1:0] len_last;
  status_e     dec_st;
  logic        dec_fin, dec_tail, dec_drop, dec_shift, dec_read;
  logic        shift_last;

  assign func     = func_e'(func_i);
  assign accept   = start && (state_q == S_IDLE);
  assign pos_ext  = CW'(position_i);
  assign len_ext  = CW'(len_q);
  assign len_last = AW'(len_q - LW'(1));
  assign shift_last = ins_q ? (cur_q == pos_q) : (cur_q == len_last);

  always_comb begin
    dec_st    = STAT_OK;
    dec_fin   = 1'b0;
    dec_tail  = 1'b0;
    dec_drop  = 1'b0;
    dec_shift = 1'b0;
    dec_read  = 1'b0;
    case (func)
      FUNC_APPEND: begin
        dec_fin = 1'b1;
        if (len_q == LEN_CAP) begin
          dec_st = STAT_FULL;
        end else begin
          dec_tail = 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (pos_ext > len_ext) begin
          dec_st  = STAT_BADPOS;
          dec_fin = 1'b1;
        end else if (len_q == LEN_CAP) begin
          dec_st  = STAT_FULL;
          dec_fin = 1'b1;
        end else if (pos_ext == len_ext) begin
          dec_fin  = 1'b1;
          dec_tail = 1'b1;
        end else begin
          dec_shift = 1'b1;
        end
      end
      FUNC_DELETE: begin
        if (len_q == '0) begin
          dec_st  = STAT_EMPTY;
          dec_fin = 1'b1;
        end else if (pos_ext >= len_ext) begin
          dec_st  = STAT_BADPOS;
          dec_fin = 1'b1;
        end else if (pos_ext + CW'(1) == len_ext) begin
          dec_fin  = 1'b1;
          dec_drop = 1'b1;
        end else begin
          dec_shift = 1'b1;
        end
      end
      FUNC_READ: begin
        if (pos_ext >= len_ext) begin
          dec_st  = STAT_BADPOS;
          dec_fin = 1'b1;
        end else begin
          dec_read = 1'b1;
        end
      end
      default: begin
        dec_fin = 1'b1;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && dec_shift) begin
          state_d = S_SHIFT;
        end else if (accept && dec_read) begin
          state_d = S_RDWAIT;
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = ins_q ? S_PLACE : S_IDLE;
      end
      S_PLACE:  state_d = S_IDLE;
      S_RDWAIT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    len_d       = len_q;
    done_d      = 1'b0;
    pend_d      = pend_q;
    ins_d       = ins_q;
    cur_d       = cur_q;
    wa_d        = wa_q;
    pos_d       = pos_q;
    val_d       = val_q;
    stat_d      = stat_q;
    rdval_d     = rdval_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = cur_q;
    case (state_q)
      S_IDLE: begin
        mem_raddr_o = AW'(position_i);
        if (accept) begin
          ins_d  = (func == FUNC_INSERT);
          pos_d  = AW'(position_i);
          val_d  = value_i;
          pend_d = 1'b0;
          if (func == FUNC_INSERT) begin
            cur_d = len_last;
          end else begin
            cur_d = AW'(position_i) + AW'(1);
          end
          if (dec_fin) begin
            done_d  = 1'b1;
            stat_d  = dec_st;
            rdval_d = '0;
          end
          if (dec_tail) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AW'(len_q);
            mem_wdata_o = value_i;
            len_d       = len_q + LW'(1);
          end
          if (dec_drop) begin
            len_d = len_q - LW'(1);
          end
        end
      end
      S_SHIFT: begin
        mem_we_o = pend_q;
        pend_d   = 1'b1;
        wa_d     = ins_q ? (cur_q + AW'(1)) : (cur_q - AW'(1));
        if (!shift_last) begin
          cur_d = ins_q ? (cur_q - AW'(1)) : (cur_q + AW'(1));
        end
      end
      S_FLUSH: begin
        mem_we_o = 1'b1;
        if (!ins_q) begin
          len_d   = len_q - LW'(1);
          done_d  = 1'b1;
          stat_d  = STAT_OK;
          rdval_d = '0;
        end
      end
      S_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        len_d       = len_q + LW'(1);
        done_d      = 1'b1;
        stat_d      = STAT_OK;
        rdval_d     = '0;
      end
      S_RDWAIT: begin
        done_d  = 1'b1;
        stat_d  = STAT_OK;
        rdval_d = mem_rdata_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q   <= ins_d;
    cur_q   <= cur_d;
    wa_q    <= wa_d;
    pos_q   <= pos_d;
    val_q   <= val_d;
    stat_q  <= stat_d;
    rdval_q <= rdval_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = stat_q;
  assign read_value_o = rdval_q;
  assign count_o      = COUNT_W'(len_q);

endmodule : ral_ctrl
`default_nettype wire

/* rtl/core/positional_array_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list_engine
// Ordered list of signed 32-bit values with append, insert, delete and read
// at a position, held in a single RAM.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------
//   command  | start / busy       | func_i, position_i, value_i
//   result   | done_o (strobe)    | status_o, read_value_o, count_o
//
// An item is taken when start is high and busy is low; its result shows on
// done_o for one cycle. Append and every error finish from the idle state, a
// read after a wait for the registered RAM read. Insert below the end and
// delete below the last entry shift the entries behind the position through
// the RAM one per cycle, insert then placing the new value; insert at the end
// and delete of the last entry finish from the idle state. Reset clears the
// length but not the RAM; no clearing pass. The result side cannot stall.
// ----------------------------------------------------------------------------
module positional_array_list_engine #(
  parameter int unsigned CAPACITY = ral_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [ral_pkg::FUNC_W-1:0]   func_i,
  input  wire logic        [ral_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [ral_pkg::DATA_W-1:0]   value_i,
  output logic                                     done_o,
  output logic             [ral_pkg::STAT_W-1:0]   status_o,
  output logic signed      [ral_pkg::DATA_W-1:0]   read_value_o,
  output logic             [ral_pkg::COUNT_W-1:0]  count_o
);

  import ral_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] rdval;

  ral_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (rdval),
    .count_o      (count_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  ral_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign read_value_o = $signed(rdval);

endmodule : positional_array_list_engine
`default_nettype wire

/* tb/sv/positional_array_list_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_engine_tb
// Self-checking bench for the array list engine. A directed table walks the
// empty, full and boundary cases of append, insert, delete and read; random
// commands then sweep the list between empty and full while the command
// side idles at different rates. Every result is compared field by field
// with a pinned reply from the table or a behavioral list model in the bench.
// ----------------------------------------------------------------------------
module positional_array_list_engine_tb;
  import ral_pkg::*;

  localparam int unsigned LIST_CAP     = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 473;
  localparam int unsigned DRAIN_CYCLES = LIST_CAP + 40;

  typedef struct {
    status_e               status;
    logic signed [31:0]    rd;
    logic [COUNT_W-1:0]    count;
  } list_reply_t;

  typedef struct {
    func_e                 op;
    logic [POS_W-1:0]      pos;
    logic signed [31:0]    val;
    bit                    pinned;
    list_reply_t           reply;
  } list_cmd_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [FUNC_W-1:0]           func_i = FUNC_APPEND;
  logic [POS_W-1:0]            position_i = '0;
  logic signed [DATA_W-1:0]    value_i = '0;
  logic                        done_o;
  logic [STAT_W-1:0]           status_o;
  logic signed [DATA_W-1:0]    read_value_o;
  logic [COUNT_W-1:0]          count_o;

  logic signed [31:0]          list_mem [LIST_CAP];
  int unsigned                 list_len = 0;
  list_reply_t                 replies_due [$];
  list_cmd_t                   cmd_table [$];
  bit                          growing = 1'b0;
  int unsigned                 items_sent = 0;
  int unsigned                 replies_seen = 0;
  int unsigned                 mismatches = 0;
  int unsigned                 full_rejects = 0;
  int unsigned                 empty_rejects = 0;

  positional_array_list_engine uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic list_reply_t apply_list_op(input func_e op, input logic [POS_W-1:0] pos,
                                                input logic signed [31:0] val);
    list_reply_t r;
    int unsigned i;
    r.status = STAT_OK;
    r.rd     = '0;
    case (op)
      FUNC_APPEND: begin
        if (list_len >= LIST_CAP) begin
          r.status = STAT_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      FUNC_INSERT: begin
        if (pos > list_len) begin
          r.status = STAT_BADPOS;
        end else if (list_len >= LIST_CAP) begin
          r.status = STAT_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      FUNC_DELETE: begin
        if (list_len == 0) begin
          r.status = STAT_EMPTY;
        end else if (pos >= list_len) begin
          r.status = STAT_BADPOS;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: begin
        if (pos >= list_len) begin
          r.status = STAT_BADPOS;
        end else begin
          r.rd = list_mem[pos];
        end
      end
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic issue(input func_e op, input logic [POS_W-1:0] pos,
                       input logic signed [31:0] val, input bit pinned,
                       input list_reply_t pinned_reply, input int unsigned idle_pct);
    list_reply_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
    predicted = apply_list_op(op, pos, val);
    if (predicted.status == STAT_FULL) full_rejects++;
    if (predicted.status == STAT_EMPTY) empty_rejects++;
    replies_due.push_back(pinned ? pinned_reply : predicted);
    items_sent++;
  endtask

  function automatic void add_cmd(input func_e op, input logic [POS_W-1:0] pos,
                                  input logic signed [31:0] val, input bit pinned,
                                  input status_e st, input logic signed [31:0] rd,
                                  input logic [COUNT_W-1:0] cnt);
    list_cmd_t c;
    c.op           = op;
    c.pos          = pos;
    c.val          = val;
    c.pinned       = pinned;
    c.reply.status = st;
    c.reply.rd     = rd;
    c.reply.count  = cnt;
    cmd_table.push_back(c);
  endfunction

  task automatic walk_table(input int unsigned idle_pct);
    foreach (cmd_table[k]) begin
      issue(cmd_table[k].op, cmd_table[k].pos, cmd_table[k].val, cmd_table[k].pinned,
            cmd_table[k].reply, idle_pct);
    end
    cmd_table.delete();
  endtask

  function automatic logic [POS_W-1:0] pick_pos(input int unsigned slots);
    case ($urandom_range(9))
      0: return POS_W'($urandom_range(255));
      1: return POS_W'(slots);
      2: return '0;
      default: return (slots == 0) ? POS_W'($urandom_range(255))
                                   : POS_W'($urandom_range(slots - 1));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random(input int unsigned idle_pct, input int unsigned n);
    list_reply_t none;
    func_e       op;
    int unsigned roll;
    none.status = STAT_OK;
    none.rd     = '0;
    none.count  = '0;
    repeat (n) begin
      if (growing && list_len >= LIST_CAP && $urandom_range(3) == 0) growing = 1'b0;
      if (!growing && list_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
      roll = $urandom_range(99);
      if (growing) begin
        op = (roll < 35) ? FUNC_APPEND : (roll < 70) ? FUNC_INSERT :
             (roll < 75) ? FUNC_DELETE : FUNC_READ;
      end else begin
        op = (roll < 65) ? FUNC_DELETE : (roll < 70) ? FUNC_APPEND :
             (roll < 75) ? FUNC_INSERT : FUNC_READ;
      end
      issue(op, (op == FUNC_INSERT) ? pick_pos(list_len + 1) : pick_pos(list_len),
            pick_value(), 1'b0, none, idle_pct);
    end
  endtask

  always @(posedge clk_i) begin : check_replies
    list_reply_t want;
    if (rst_ni && done_o) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no command pending", $realtime);
      end else begin
        want = replies_due.pop_front();
        if (status_o !== want.status || read_value_o !== want.rd || count_o !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch status %0d/%0d read_value %0d/%0d count %0d/%0d (exp/act)",
                     $realtime, want.status, status_o, want.rd, read_value_o,
                     want.count, count_o);
          end
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    list_reply_t none;
    none.status = STAT_OK;
    none.rd     = '0;
    none.count  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_cmd(FUNC_READ,   8'd0,   32'sd0,          1'b1, STAT_BADPOS, 32'sd0,          9'd0);
    add_cmd(FUNC_DELETE, 8'd0,   32'sd0,          1'b1, STAT_EMPTY,  32'sd0,          9'd0);
    add_cmd(FUNC_DELETE, 8'd255, 32'sd0,          1'b1, STAT_EMPTY,  32'sd0,          9'd0);
    add_cmd(FUNC_INSERT, 8'd1,   32'sd7,          1'b1, STAT_BADPOS, 32'sd0,          9'd0);
    add_cmd(FUNC_INSERT, 8'd255, 32'sd7,          1'b1, STAT_BADPOS, 32'sd0,          9'd0);
    add_cmd(FUNC_INSERT, 8'd0,   32'sh8000_0000,  1'b1, STAT_OK,     32'sd0,          9'd1);
    add_cmd(FUNC_APPEND, 8'd255, 32'sh7fff_ffff,  1'b1, STAT_OK,     32'sd0,          9'd2);
    add_cmd(FUNC_READ,   8'd0,   32'shffff_ffff,  1'b1, STAT_OK,     32'sh8000_0000,  9'd2);
    add_cmd(FUNC_READ,   8'd1,   32'sd0,          1'b1, STAT_OK,     32'sh7fff_ffff,  9'd2);
    add_cmd(FUNC_READ,   8'd2,   32'sd0,          1'b1, STAT_BADPOS, 32'sd0,          9'd2);
    add_cmd(FUNC_INSERT, 8'd1,   32'sh0000_1234,  1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_INSERT, 8'd3,   32'shffff_ffff,  1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_INSERT, 8'd5,   32'sd9,          1'b1, STAT_BADPOS, 32'sd0,          9'd4);
    add_cmd(FUNC_READ,   8'd255, 32'sd0,          1'b1, STAT_BADPOS, 32'sd0,          9'd4);
    add_cmd(FUNC_READ,   8'd1,   32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_DELETE, 8'd0,   32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_DELETE, 8'd3,   32'sd0,          1'b1, STAT_BADPOS, 32'sd0,          9'd3);
    add_cmd(FUNC_DELETE, 8'd2,   32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_READ,   8'd0,   32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_READ,   8'd1,   32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    walk_table(18);

    while (list_len < LIST_CAP) issue(FUNC_APPEND, POS_W'($urandom()), $urandom(), 1'b0, none, 0);

    add_cmd(FUNC_APPEND, 8'd0,   32'sd1,          1'b1, STAT_FULL,   32'sd0,          9'd256);
    add_cmd(FUNC_INSERT, 8'd0,   32'sd2,          1'b1, STAT_FULL,   32'sd0,          9'd256);
    add_cmd(FUNC_INSERT, 8'd255, 32'sd3,          1'b1, STAT_FULL,   32'sd0,          9'd256);
    add_cmd(FUNC_READ,   8'd255, 32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_DELETE, 8'd255, 32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    add_cmd(FUNC_DELETE, 8'd0,   32'sd0,          1'b0, STAT_OK,     32'sd0,          9'd0);
    walk_table(18);

    run_random(18, RANDOM_ITEMS);
    run_random(61, RANDOM_ITEMS);
    run_random(0, RANDOM_ITEMS);
    start <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d commands issued, %0d results checked, %0d mismatches",
             items_sent, replies_seen, mismatches);
    $display("list swept empty to full: %0d full and %0d empty rejections",
             full_rejects, empty_rejects);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
